### hdl/rhsv_pkg.sv
package rhsv_pkg;

	localparam int CH_W      = 8;
	localparam int SAT_W     = 16;
	localparam int HUE_OUT_W = 16;
	localparam int HREM_W    = 11;

	localparam logic [SAT_W-1:0] SAT_MAX = '1;

	typedef struct packed {
		logic            valid;
		logic            gray;
		logic            full;
		logic [CH_W-1:0] value;
	} ctl_t;

	typedef struct packed {
		logic [CH_W-1:0]  rem;
		logic [CH_W-1:0]  div;
		logic [SAT_W-1:0] q;
	} sat_t;

endpackage

### hdl/rhsv_front.sv
module rhsv_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rhsv_pkg::CH_W-1:0]       red,
	input  logic [rhsv_pkg::CH_W-1:0]       green,
	input  logic [rhsv_pkg::CH_W-1:0]       blue,
	output rhsv_pkg::ctl_t                  ctl,
	output rhsv_pkg::sat_t                  sat,
	output logic [rhsv_pkg::HREM_W-1:0]     hrem,
	output logic [rhsv_pkg::HREM_W-1:0]     hdiv
);

	logic [rhsv_pkg::CH_W-1:0]       mx, mn, delta;
	logic [rhsv_pkg::HREM_W-1:0]     six_d;
	logic signed [rhsv_pkg::HREM_W:0] num;
	logic signed [rhsv_pkg::HREM_W:0] sr, sg, sb, sd;

	logic                            valid_q;
	logic                            gray_q, full_q;
	logic [rhsv_pkg::CH_W-1:0]       mx_q, delta_q;
	logic [rhsv_pkg::HREM_W-1:0]     hrem_q, hdiv_q;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		six_d = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
		sr = $signed({4'b0000, red});
		sg = $signed({4'b0000, green});
		sb = $signed({4'b0000, blue});
		sd = $signed({4'b0000, delta});
		priority if (red == mx) begin
			num = sg - sb;
		end else if (green == mx) begin
			num = (sd <<< 1) + sb - sr;
		end else begin
			num = (sd <<< 2) + sr - sg;
		end
		if (num < 0) num = num + $signed({1'b0, six_d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		gray_q  <= (delta == '0);
		full_q  <= (mn == '0);
		mx_q    <= mx;
		delta_q <= delta;
		hrem_q  <= num[rhsv_pkg::HREM_W-1:0];
		hdiv_q  <= six_d;
	end

	assign ctl.valid = valid_q;
	assign ctl.gray  = gray_q;
	assign ctl.full  = full_q;
	assign ctl.value = mx_q;
	assign sat.rem   = delta_q;
	assign sat.div   = mx_q;
	assign sat.q     = '0;
	assign hrem      = hrem_q;
	assign hdiv      = hdiv_q;

endmodule

### hdl/rhsv_cell.sv
module rhsv_cell #(
	parameter int HQ_W   = 16,
	parameter bit SAT_ON = 1'b1,
	parameter bit HUE_ON = 1'b1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rhsv_pkg::ctl_t              prev_ctl,
	input  rhsv_pkg::sat_t              prev_sat,
	input  logic [rhsv_pkg::HREM_W-1:0] prev_hrem,
	input  logic [rhsv_pkg::HREM_W-1:0] prev_hdiv,
	input  logic [HQ_W-1:0]             prev_hq,
	output rhsv_pkg::ctl_t              next_ctl,
	output rhsv_pkg::sat_t              next_sat,
	output logic [rhsv_pkg::HREM_W-1:0] next_hrem,
	output logic [rhsv_pkg::HREM_W-1:0] next_hdiv,
	output logic [HQ_W-1:0]             next_hq
);

	logic [rhsv_pkg::CH_W:0]     st, sdiff;
	logic                        sge;
	logic [rhsv_pkg::HREM_W:0]   ht, hdiff;
	logic                        hge;
	rhsv_pkg::sat_t              sat_d;
	logic [rhsv_pkg::HREM_W-1:0] hrem_d;
	logic [HQ_W-1:0]             hq_d;

	logic                        valid_q;
	rhsv_pkg::ctl_t              ctl_q;
	rhsv_pkg::sat_t              sat_q;
	logic [rhsv_pkg::HREM_W-1:0] hrem_q, hdiv_q;
	logic [HQ_W-1:0]             hq_q;

	always_comb begin
		st    = {prev_sat.rem, 1'b0};
		sge   = (st >= {1'b0, prev_sat.div});
		sdiff = st - {1'b0, prev_sat.div};
		sat_d = prev_sat;
		if (SAT_ON) begin
			sat_d.rem = sge ? sdiff[rhsv_pkg::CH_W-1:0] : st[rhsv_pkg::CH_W-1:0];
			sat_d.q   = {prev_sat.q[rhsv_pkg::SAT_W-2:0], sge};
		end

		ht     = {prev_hrem, 1'b0};
		hge    = (ht >= {1'b0, prev_hdiv});
		hdiff  = ht - {1'b0, prev_hdiv};
		hrem_d = prev_hrem;
		hq_d   = prev_hq;
		if (HUE_ON) begin
			hrem_d = hge ? hdiff[rhsv_pkg::HREM_W-1:0] : ht[rhsv_pkg::HREM_W-1:0];
			hq_d   = {prev_hq[HQ_W-2:0], hge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_q  <= prev_ctl;
		sat_q  <= sat_d;
		hrem_q <= hrem_d;
		hdiv_q <= prev_hdiv;
		hq_q   <= hq_d;
	end

	always_comb begin
		next_ctl       = ctl_q;
		next_ctl.valid = valid_q;
	end

	assign next_sat  = sat_q;
	assign next_hrem = hrem_q;
	assign next_hdiv = hdiv_q;
	assign next_hq   = hq_q;

endmodule

### hdl/rgb_to_hsv_pixel.sv
// RGB to HSV converter for 8-bit pixels. Raise start with a pixel on red, green
// and blue; busy is always low, so a pixel may be given in every cycle. Each
// pixel yields one result on hue, saturation and value with done high for one
// cycle, after the front stage and the cell chain; results come in order and
// cannot be held off. Behind one register stage that finds max, min and the
// hue numerator, restoring-division cells give one quotient bit of hue (first
// HUE_BITS cells) and of saturation (first 16) per cell. No reset pass.
module rgb_to_hsv_pixel #(
	parameter int HUE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rhsv_pkg::CH_W-1:0]          red,
	input  logic [rhsv_pkg::CH_W-1:0]          green,
	input  logic [rhsv_pkg::CH_W-1:0]          blue,
	output logic                               done,
	output logic [rhsv_pkg::HUE_OUT_W-1:0]     hue,
	output logic [rhsv_pkg::SAT_W-1:0]         saturation,
	output logic [rhsv_pkg::CH_W-1:0]          value
);

	localparam int N   = (HUE_BITS > rhsv_pkg::SAT_W) ? HUE_BITS : rhsv_pkg::SAT_W;
	localparam int LAT = N + 1;

	rhsv_pkg::ctl_t              ctl  [0:N];
	rhsv_pkg::sat_t              sat  [0:N];
	logic [rhsv_pkg::HREM_W-1:0] hrem [0:N];
	logic [rhsv_pkg::HREM_W-1:0] hdiv [0:N];
	logic [HUE_BITS-1:0]         hq   [0:N];
	logic [rhsv_pkg::HUE_OUT_W+HUE_BITS-1:0] hue_x;

	assign busy = 1'b0;

	rhsv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.ctl    (ctl[0]),
		.sat    (sat[0]),
		.hrem   (hrem[0]),
		.hdiv   (hdiv[0])
	);

	assign hq[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		rhsv_cell #(
			.HQ_W   (HUE_BITS),
			.SAT_ON (i < rhsv_pkg::SAT_W),
			.HUE_ON (i < HUE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.prev_ctl  (ctl[i]),
			.prev_sat  (sat[i]),
			.prev_hrem (hrem[i]),
			.prev_hdiv (hdiv[i]),
			.prev_hq   (hq[i]),
			.next_ctl  (ctl[i+1]),
			.next_sat  (sat[i+1]),
			.next_hrem (hrem[i+1]),
			.next_hdiv (hdiv[i+1]),
			.next_hq   (hq[i+1])
		);
	end

	assign hue_x = {{rhsv_pkg::HUE_OUT_W{1'b0}}, hq[N]};

	always_comb begin
		done  = ctl[N].valid;
		value = ctl[N].value;
		priority if (ctl[N].gray) begin
			hue        = '0;
			saturation = '0;
		end else if (ctl[N].full) begin
			hue        = hue_x[rhsv_pkg::HUE_OUT_W-1:0];
			saturation = rhsv_pkg::SAT_MAX;
		end else begin
			hue        = hue_x[rhsv_pkg::HUE_OUT_W-1:0];
			saturation = sat[N].q;
		end
	end

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a request");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturation == '0) |-> (hue == '0))
		else $error("gray pixel with nonzero hue");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && value == '0) |-> (saturation == '0))
		else $error("black pixel with nonzero saturation");

	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ctl[N].gray && ctl[N].full) |-> (saturation == rhsv_pkg::SAT_MAX))
		else $error("zero minimum without full saturation");

endmodule

### sim/hsv_checker.sv
module hsv_checker #(
	parameter int HUE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [rhsv_pkg::CH_W-1:0]      red,
	input  logic [rhsv_pkg::CH_W-1:0]      green,
	input  logic [rhsv_pkg::CH_W-1:0]      blue,
	input  logic                           done,
	input  logic [rhsv_pkg::HUE_OUT_W-1:0] hue,
	input  logic [rhsv_pkg::SAT_W-1:0]     saturation,
	input  logic [rhsv_pkg::CH_W-1:0]      value,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [rhsv_pkg::HUE_OUT_W-1:0] hue;
		logic [rhsv_pkg::SAT_W-1:0]     sat;
		logic [rhsv_pkg::CH_W-1:0]      val;
	} hsv_t;

	hsv_t expected_hsv[$];

	function automatic hsv_t convert_pixel(logic [rhsv_pkg::CH_W-1:0] r,
			logic [rhsv_pkg::CH_W-1:0] g, logic [rhsv_pkg::CH_W-1:0] b);
		hsv_t        px;
		int          mx;
		int          mn;
		int          delta;
		int          num;
		int unsigned sq;
		logic [63:0] hq;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		px = '0;
		px.val = rhsv_pkg::CH_W'(mx);
		if (delta != 0) begin
			sq = (32'(delta) << 16) / 32'(mx);
			px.sat = (sq > 65535) ? rhsv_pkg::SAT_MAX : rhsv_pkg::SAT_W'(sq);
			if (int'(r) == mx) begin
				num = int'(g) - int'(b);
			end else if (int'(g) == mx) begin
				num = 2 * delta + int'(b) - int'(r);
			end else begin
				num = 4 * delta + int'(r) - int'(g);
			end
			if (num < 0) num += 6 * delta;
			hq = (64'(num) << HUE_BITS) / 64'(6 * delta);
			px.hue = hq[rhsv_pkg::HUE_OUT_W-1:0];
		end
		return px;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		hsv_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_hsv.size() == 0) begin
					$display("%0t: unexpected result hue=%h saturation=%h value=%h",
						$time, hue, saturation, value);
					errors++;
				end else begin
					want = expected_hsv.pop_front();
					if (hue !== want.hue) begin
						$display("%0t: hue expected %h actual %h", $time, want.hue, hue);
						errors++;
					end
					if (saturation !== want.sat) begin
						$display("%0t: saturation expected %h actual %h",
							$time, want.sat, saturation);
						errors++;
					end
					if (value !== want.val) begin
						$display("%0t: value expected %h actual %h", $time, want.val, value);
						errors++;
					end
				end
			end
			if (start && !busy) expected_hsv.push_back(convert_pixel(red, green, blue));
			pending = expected_hsv.size();
		end
	end

endmodule

### sim/rgb_to_hsv_pixel_tb.sv
module rgb_to_hsv_pixel_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HUE_W     = 16;
	localparam int N_RANDOM  = 700;
	localparam int DRAIN_MAX = 1000;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic [rhsv_pkg::CH_W-1:0]            red;
	logic [rhsv_pkg::CH_W-1:0]            green;
	logic [rhsv_pkg::CH_W-1:0]            blue;
	logic                                 done;
	logic [rhsv_pkg::HUE_OUT_W-1:0]       hue;
	logic [rhsv_pkg::SAT_W-1:0]           saturation;
	logic [rhsv_pkg::CH_W-1:0]            value;
	int                                   errors;
	int                                   pending;
	bit                                   quiet;

	rgb_to_hsv_pixel #(.HUE_BITS(HUE_W)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.value      (value)
	);

	hsv_checker #(.HUE_BITS(HUE_W)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.value      (value),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [rhsv_pkg::CH_W-1:0] edge_channel();
		case ($urandom_range(2))
			0: return '0;
			1: return '1;
			default: return rhsv_pkg::CH_W'($urandom);
		endcase
	endfunction

	task automatic idle_gap();
		while (!quiet && $urandom_range(99) < 16) begin
			@(negedge clk);
			start <= 1'b0;
			red   <= rhsv_pkg::CH_W'($urandom);
			green <= rhsv_pkg::CH_W'($urandom);
			blue  <= rhsv_pkg::CH_W'($urandom);
		end
	endtask

	task automatic send_pixel(logic [rhsv_pkg::CH_W-1:0] r, logic [rhsv_pkg::CH_W-1:0] g,
			logic [rhsv_pkg::CH_W-1:0] b);
		idle_gap();
		@(negedge clk);
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [rhsv_pkg::CH_W-1:0] r, g, b, v, w;
		int                        mode;
		int                        waited;
		arst_n = 1'b0;
		start  = 1'b0;
		red    = '0;
		green  = '0;
		blue   = '0;
		quiet  = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd200, 8'd10, 8'd199);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd1);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd1, 8'd2, 8'd3);
		send_pixel(8'd3, 8'd1, 8'd2);
		send_pixel(8'd2, 8'd3, 8'd1);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd85, 8'd170, 8'd255);

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 400 && i < 550);
			if (i == 350) begin
				@(negedge clk);
				start <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			mode = $urandom_range(99);
			v = rhsv_pkg::CH_W'($urandom);
			w = rhsv_pkg::CH_W'($urandom);
			if (mode < 60) begin
				r = rhsv_pkg::CH_W'($urandom);
				g = rhsv_pkg::CH_W'($urandom);
				b = rhsv_pkg::CH_W'($urandom);
			end else if (mode < 72) begin
				r = v;
				g = v;
				b = v;
			end else if (mode < 88) begin
				case ($urandom_range(2))
					0: begin r = v; g = v; b = w; end
					1: begin r = w; g = v; b = v; end
					default: begin r = v; g = w; b = v; end
				endcase
			end else begin
				r = edge_channel();
				g = edge_channel();
				b = edge_channel();
			end
			send_pixel(r, g, b);
		end

		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (HUE_W + 4) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
